FILE: design/sncv_pkg.sv
// ----------------------------------------------------------------------------
// sncv_pkg
// Shared types, codes and rounding helpers of the normalized convolution core.
// ----------------------------------------------------------------------------
package sncv_pkg;

  // request codes of an input item
  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_HCOEF = 2'd1;
  localparam logic [1:0] REQ_VCOEF = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_OUT_COLS    = 3'd0;
  localparam logic [2:0] CFG_PADDED_COLS = 3'd1;
  localparam logic [2:0] CFG_OUT_ROWS    = 3'd2;
  localparam logic [2:0] CFG_TAPS_COLS   = 3'd3;
  localparam logic [2:0] CFG_TAPS_ROWS   = 3'd4;
  localparam logic [2:0] CFG_NODATA_EN   = 3'd5;
  localparam logic [2:0] CFG_NODATA_VAL  = 3'd6;

  // fixed widths (cover the largest parameter values)
  localparam int COL_W  = 14;
  localparam int ROW_W  = 17;
  localparam int TAP_W  = 5;
  localparam int RS_W   = 40;
  localparam int RW_W   = 24;
  localparam int CTR_W  = 16;
  localparam int LINE_W = RS_W + RW_W + CTR_W;
  localparam int HS_W   = 53;
  localparam int HW_W   = 38;
  localparam int VS_W   = 61;
  localparam int VW_W   = 45;
  localparam int DIV_W  = 64;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [COL_W-1:0] pc;
    logic [COL_W-1:0] ocn;
    logic [15:0]      orows;
    logic [TAP_W-1:0] tc;
    logic [TAP_W-1:0] tr;
    logic             nd_en;
    logic [15:0]      nd_val;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TAP_W-1:0]   idx;
    logic signed [15:0] coef;
    logic signed [31:0] pw;
    logic [15:0]        wt;
    logic               hemit;
    logic               vemit;
    logic [COL_W-1:0]   oc;
    logic [15:0]        orow;
    logic [TAP_W-1:0]   ring;
    logic               last;
  } job_t;

  // round half away from zero, drop 14 fraction bits
  function automatic logic signed [RS_W-1:0] round_rs(input logic signed [HS_W-1:0] x);
    logic [HS_W:0] mag;
    logic [HS_W:0] m;
    mag = x[HS_W-1] ? (HS_W+1)'(-x) : (HS_W+1)'(x);
    m = (mag + (HS_W+1)'(8192)) >> 14;
    return x[HS_W-1] ? -$signed(m[RS_W-1:0]) : $signed(m[RS_W-1:0]);
  endfunction

  function automatic logic signed [RW_W-1:0] round_rw(input logic signed [HW_W-1:0] x);
    logic [HW_W:0] mag;
    logic [HW_W:0] m;
    mag = x[HW_W-1] ? (HW_W+1)'(-x) : (HW_W+1)'(x);
    m = (mag + (HW_W+1)'(8192)) >> 14;
    return x[HW_W-1] ? -$signed(m[RW_W-1:0]) : $signed(m[RW_W-1:0]);
  endfunction

endpackage

FILE: design/sncv_ram.sv
// ----------------------------------------------------------------------------
// sncv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sncv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sncv_queue.sv
// ----------------------------------------------------------------------------
// sncv_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sncv_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sncv_pkg::job_t  push_job,
  input  logic            pop,
  output sncv_pkg::job_t  head_job,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sncv_pkg::job_t    slot_r [DEPTH];
  logic [PW-1:0]     wptr_r;
  logic [PW-1:0]     rptr_r;
  logic [PW:0]       count_r;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: design/sncv_front.sv
// ----------------------------------------------------------------------------
// sncv_front
// Accepts items, classifies them, derives weights and stream position.
// ----------------------------------------------------------------------------
module sncv_front #(
  parameter int MAX_TAPS   = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sncv_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic signed [15:0]  in_pixel_value,
  input  logic [15:0]         in_pixel_weight,
  input  logic [3:0]          in_coef_index,
  input  logic signed [15:0]  in_coef_value,
  input  logic                q_full,
  output logic                q_push,
  output sncv_pkg::job_t      q_job
);

  localparam int PIX_W = (PIXEL_BITS > 16) ? 16 : PIXEL_BITS;
  localparam int CW = sncv_pkg::COL_W;
  localparam int RW = sncv_pkg::ROW_W;
  localparam int TW = sncv_pkg::TAP_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [TW-1:0] ring_r, ring_nxt;

  logic               accept;
  logic signed [15:0] pix_s;
  logic signed [15:0] nd_s;
  logic [15:0]        w_eff;
  logic signed [32:0] pw_full;
  logic [TW-1:0]      tc1, tr1;
  logic [CW-1:0]      oc, span, lim_c, lastcol;
  logic [CW:0]        pc1;
  logic [RW-1:0]      orow_full;
  logic               hemit, vemit, is_pix, is_coef;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pix_s[i] = (i < PIX_W) ? in_pixel_value[i] : in_pixel_value[PIX_W-1];
      nd_s[i]  = (i < PIX_W) ? cfg.nd_val[i] : cfg.nd_val[PIX_W-1];
    end
    w_eff = (in_pixel_weight > 16'd32768) ? 16'd32768 : in_pixel_weight;
    if (cfg.nd_en && (pix_s == nd_s)) begin
      w_eff = '0;
    end
    pw_full = pix_s * $signed({1'b0, w_eff});

    tc1   = cfg.tc - 1'b1;
    tr1   = cfg.tr - 1'b1;
    oc    = col_r - CW'(tc1);
    hemit = (col_r >= CW'(tc1)) && (oc < cfg.ocn);
    orow_full = row_r - RW'(tr1);
    vemit = (row_r >= RW'(tr1)) && (orow_full < RW'(cfg.orows));

    // last produced column: narrow padding may cut the row short
    pc1  = (CW+1)'(cfg.pc) + 1'b1;
    span = CW'(pc1 - (CW+1)'(cfg.tc));
    if (pc1 > (CW+1)'(cfg.tc)) begin
      lim_c = (cfg.ocn < span) ? cfg.ocn : span;
    end else begin
      lim_c = cfg.ocn;
    end
    lastcol = lim_c - 1'b1;

    is_pix  = (in_req_type == sncv_pkg::REQ_PIXEL);
    is_coef = ((in_req_type == sncv_pkg::REQ_HCOEF) || (in_req_type == sncv_pkg::REQ_VCOEF))
              && (32'(in_coef_index) < MAX_TAPS);

    col_nxt  = col_r;
    row_nxt  = row_r;
    ring_nxt = ring_r;
    if (accept && is_pix) begin
      if ((col_r + 1'b1) >= cfg.pc) begin
        col_nxt = '0;
        if ((row_r + 1'b1) >= (RW'(cfg.orows) + RW'(tr1))) begin
          row_nxt  = '0;
          ring_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          ring_nxt = (32'(ring_r) == MAX_TAPS - 1) ? '0 : ring_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    q_push     = accept && (is_pix || is_coef);
    q_job.kind = in_req_type;
    q_job.idx  = TW'(in_coef_index);
    q_job.coef = in_coef_value;
    q_job.pw   = $signed(pw_full[31:0]);
    q_job.wt   = w_eff;
    q_job.hemit = hemit;
    q_job.vemit = vemit;
    q_job.oc    = oc;
    q_job.orow  = orow_full[15:0];
    q_job.ring  = ring_r;
    q_job.last  = (orow_full == RW'(cfg.orows) - 1'b1) && (oc == lastcol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ring_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ring_r <= ring_nxt;
    end
  end

endmodule

FILE: design/sncv_back.sv
// ----------------------------------------------------------------------------
// sncv_back
// Window, horizontal and vertical MAC passes, line buffers and divider.
// ----------------------------------------------------------------------------
module sncv_back #(
  parameter int MAX_COLS   = 2048,
  parameter int MAX_TAPS   = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sncv_pkg::cfg_t      cfg,
  input  sncv_pkg::job_t      head_job,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_result_value,
  output logic [15:0]         out_out_row,
  output logic [10:0]         out_out_col,
  output logic                out_skipped,
  output logic                out_last
);

  localparam int PIX_W = (PIXEL_BITS > 16) ? 16 : PIXEL_BITS;
  localparam int QB    = PIX_W + 1;
  localparam int RGW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int DEPTH = MAX_TAPS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = sncv_pkg::TAP_W;
  localparam int RS_W  = sncv_pkg::RS_W;
  localparam int RW_W  = sncv_pkg::RW_W;
  localparam int LW    = sncv_pkg::LINE_W;
  localparam int HS_W  = sncv_pkg::HS_W;
  localparam int HW_W  = sncv_pkg::HW_W;
  localparam int VS_W  = sncv_pkg::VS_W;
  localparam int VW_W  = sncv_pkg::VW_W;
  localparam int DW    = sncv_pkg::DIV_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HMAC = 3'd1;
  localparam logic [2:0] ST_HWR  = 3'd2;
  localparam logic [2:0] ST_VMAC = 3'd3;
  localparam logic [2:0] ST_DSET = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]          state_r;
  sncv_pkg::job_t      job_r;
  logic signed [15:0]  hc_r [MAX_TAPS];
  logic signed [15:0]  vc_r [MAX_TAPS];
  logic signed [31:0]  win_pw_r [MAX_TAPS];
  logic [15:0]         win_w_r [MAX_TAPS];
  logic [TW:0]         cnt_r;
  logic signed [47:0]  hp_s_r;
  logic signed [32:0]  hp_w_r;
  logic signed [HS_W-1:0] hacc_s_r;
  logic signed [HW_W-1:0] hacc_w_r;
  logic [15:0]         hctr_r;
  logic [TW-1:0]       rk_r;
  logic signed [55:0]  vp_s_r;
  logic signed [39:0]  vp_w_r;
  logic signed [VS_W-1:0] vacc_s_r;
  logic signed [VW_W-1:0] vacc_w_r;
  logic [15:0]         vctr_r;
  logic [DW-1:0]       rem_r, dsh_r;
  logic [16:0]         q_r;
  logic                neg_r, sat_r, zero_r, skip_r;

  // ram
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [LW-1:0]   ram_wdata, ram_rdata;

  logic [TW-1:0]   tc1, tr1, win_idx, vk, rk_start;
  logic [VS_W-1:0] mag_s;
  logic [DW-1:0]   num, den;
  logic signed [17:0] qs, lim, val;
  logic            out_free;
  logic            w_nonpos;
  logic signed [RS_W-1:0] rd_rs;
  logic signed [RW_W-1:0] rd_rw;

  sncv_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    tc1     = cfg.tc - 1'b1;
    tr1     = cfg.tr - 1'b1;
    win_idx = tc1 - TW'(cnt_r);
    vk      = TW'(cnt_r) - 1'b1;
    rk_start = (job_r.ring >= tr1) ? job_r.ring - tr1 : job_r.ring + TW'(MAX_TAPS) - tr1;
    rd_rs   = $signed(ram_rdata[LW-1 -: RS_W]);
    rd_rw   = $signed(ram_rdata[LW-RS_W-1 -: RW_W]);

    ram_we    = (state_r == ST_HWR);
    ram_waddr = AW'(job_r.ring) * AW'(MAX_COLS) + AW'(job_r.oc);
    ram_wdata = {sncv_pkg::round_rs(hacc_s_r), sncv_pkg::round_rw(hacc_w_r), hctr_r};
    ram_re    = (state_r == ST_VMAC) && (cnt_r < (TW+1)'(cfg.tr));
    ram_raddr = AW'(rk_r) * AW'(MAX_COLS) + AW'(job_r.oc);

    // weight sum zero or negative
    w_nonpos = vacc_w_r[VW_W-1] || (vacc_w_r == '0);

    mag_s = vacc_s_r[VS_W-1] ? VS_W'(-vacc_s_r) : VS_W'(vacc_s_r);
    num   = (DW'(mag_s) << 1) + DW'(vacc_w_r);
    den   = DW'(vacc_w_r) << 1;

    qs  = $signed({1'b0, q_r});
    lim = 18'sd1 <<< (PIX_W - 1);
    if (zero_r) begin
      val = '0;
    end else if (neg_r) begin
      val = (sat_r || (qs > lim)) ? -lim : -qs;
    end else begin
      val = (sat_r || (qs > lim - 18'sd1)) ? lim - 18'sd1 : qs;
    end

    out_free = !out_valid || !out_stall;
    q_pop    = (state_r == ST_IDLE) && !q_empty;
  end

  // coefficient and window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hc_r[i] <= '0;
        vc_r[i] <= '0;
      end
    end else if (q_pop) begin
      if (head_job.kind == sncv_pkg::REQ_HCOEF) begin
        hc_r[head_job.idx[RGW-1:0]] <= head_job.coef;
      end
      if (head_job.kind == sncv_pkg::REQ_VCOEF) begin
        vc_r[head_job.idx[RGW-1:0]] <= head_job.coef;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (head_job.kind == sncv_pkg::REQ_PIXEL)) begin
      win_pw_r[0] <= head_job.pw;
      win_w_r[0]  <= head_job.wt;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_pw_r[i] <= win_pw_r[i-1];
        win_w_r[i]  <= win_w_r[i-1];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          job_r    <= head_job;
          hacc_s_r <= '0;
          hacc_w_r <= '0;
          cnt_r    <= '0;
        end
      end
      ST_HMAC: begin
        if (cnt_r < (TW+1)'(cfg.tc)) begin
          hp_s_r <= hc_r[cnt_r[RGW-1:0]] * win_pw_r[win_idx[RGW-1:0]];
          hp_w_r <= hc_r[cnt_r[RGW-1:0]] * $signed({1'b0, win_w_r[win_idx[RGW-1:0]]});
          if (TW'(cnt_r) == (cfg.tc >> 1)) begin
            hctr_r <= win_w_r[win_idx[RGW-1:0]];
          end
        end
        if (cnt_r != '0) begin
          hacc_s_r <= hacc_s_r + HS_W'(hp_s_r);
          hacc_w_r <= hacc_w_r + HW_W'(hp_w_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_HWR: begin
        cnt_r    <= '0;
        rk_r     <= rk_start;
        vacc_s_r <= '0;
        vacc_w_r <= '0;
      end
      ST_VMAC: begin
        if (ram_re) begin
          rk_r <= (32'(rk_r) == MAX_TAPS - 1) ? '0 : rk_r + 1'b1;
        end
        if ((cnt_r != '0) && (cnt_r <= (TW+1)'(cfg.tr))) begin
          vp_s_r <= vc_r[vk[RGW-1:0]] * rd_rs;
          vp_w_r <= vc_r[vk[RGW-1:0]] * rd_rw;
          if (vk == (cfg.tr >> 1)) begin
            vctr_r <= ram_rdata[15:0];
          end
        end
        if (cnt_r >= (TW+1)'(2)) begin
          vacc_s_r <= vacc_s_r + VS_W'(vp_s_r);
          vacc_w_r <= vacc_w_r + VW_W'(vp_w_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_DSET: begin
        skip_r <= (vctr_r == '0);
        zero_r <= (vctr_r == '0) || w_nonpos;
        neg_r  <= vacc_s_r[VS_W-1];
        sat_r  <= (num >= (den << QB));
        rem_r  <= num;
        dsh_r  <= den << (QB - 1);
        q_r    <= '0;
        cnt_r  <= '0;
      end
      ST_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          q_r   <= {q_r[15:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_pop && (head_job.kind == sncv_pkg::REQ_PIXEL) && head_job.hemit) begin
            state_r <= ST_HMAC;
          end
        end
        ST_HMAC: begin
          if (cnt_r == (TW+1)'(cfg.tc)) begin
            state_r <= ST_HWR;
          end
        end
        ST_HWR:  state_r <= job_r.vemit ? ST_VMAC : ST_IDLE;
        ST_VMAC: begin
          if (cnt_r == (TW+1)'(cfg.tr) + 1'b1) begin
            state_r <= ST_DSET;
          end
        end
        ST_DSET: begin
          if ((vctr_r == '0) || w_nonpos || (num >= (den << QB))) begin
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_r == (TW+1)'(QB - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_result_value <= val[15:0];
      out_out_row      <= job_r.orow;
      out_out_col      <= job_r.oc[10:0];
      out_skipped      <= skip_r;
      out_last         <= job_r.last;
    end
  end

endmodule

FILE: design/separable_normalized_convolution_core.sv
// ----------------------------------------------------------------------------
// separable_normalized_convolution_core
// Streamed separable normalized 2-D convolution with weights and no-data.
// ----------------------------------------------------------------------------
// Coefficient load: taken by the back end from the queue head while it is idle.
// Pixel outside the output span: shifted into the window only; inside a row only:
//   horizontal tap MAC (one tap product per cycle), then the line-buffer write.
// Pixel producing a result: tap MAC, line-buffer write, vertical MAC with a line-buffer
//   read per row, divider setup, the one-bit divider and the output register.
// Reset (synchronous, rst_n low): registers to defaults, coefficients and
//   counters cleared; line buffers are not cleared.
module separable_normalized_convolution_core #(
  parameter int MAX_COLS   = 2048,
  parameter int MAX_TAPS   = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_pixel_value,
  input  logic [15:0]        in_pixel_weight,
  input  logic [3:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_result_value,
  output logic [15:0]        out_out_row,
  output logic [10:0]        out_out_col,
  output logic               out_skipped,
  output logic               out_last
);

  localparam int CW = sncv_pkg::COL_W;
  localparam int TW = sncv_pkg::TAP_W;

  // raw configuration registers
  logic [11:0] out_cols_r, padded_cols_r;
  logic [15:0] out_rows_r, nodata_value_r;
  logic [3:0]  taps_cols_r, taps_rows_r;
  logic        nodata_enable_r;

  sncv_pkg::cfg_t cfg;
  sncv_pkg::job_t q_in_job, q_head_job;
  logic           q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cols_r      <= 12'd1;
      padded_cols_r   <= 12'd1;
      out_rows_r      <= 16'd1;
      taps_cols_r     <= 4'd1;
      taps_rows_r     <= 4'd1;
      nodata_enable_r <= 1'b0;
      nodata_value_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sncv_pkg::CFG_OUT_COLS:    out_cols_r      <= cfg_data[11:0];
        sncv_pkg::CFG_PADDED_COLS: padded_cols_r   <= cfg_data[11:0];
        sncv_pkg::CFG_OUT_ROWS:    out_rows_r      <= cfg_data;
        sncv_pkg::CFG_TAPS_COLS:   taps_cols_r     <= cfg_data[3:0];
        sncv_pkg::CFG_TAPS_ROWS:   taps_rows_r     <= cfg_data[3:0];
        sncv_pkg::CFG_NODATA_EN:   nodata_enable_r <= cfg_data[0];
        sncv_pkg::CFG_NODATA_VAL:  nodata_value_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp out-of-range settings to their legal span
  always_comb begin
    cfg.pc  = (padded_cols_r == '0) ? CW'(1) :
              ((32'(padded_cols_r) > MAX_COLS) ? CW'(MAX_COLS) : CW'(padded_cols_r));
    cfg.ocn = (out_cols_r == '0) ? CW'(1) :
              ((32'(out_cols_r) > MAX_COLS) ? CW'(MAX_COLS) : CW'(out_cols_r));
    cfg.orows = (out_rows_r == '0) ? 16'd1 : out_rows_r;
    cfg.tc  = (taps_cols_r == '0) ? TW'(1) :
              ((32'(taps_cols_r) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_cols_r));
    cfg.tr  = (taps_rows_r == '0) ? TW'(1) :
              ((32'(taps_rows_r) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_rows_r));
    cfg.nd_en  = nodata_enable_r;
    cfg.nd_val = nodata_value_r;
  end

  // front: weights, no-data, stream position
  sncv_front #(.MAX_TAPS(MAX_TAPS), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_pixel_value  (in_pixel_value),
    .in_pixel_weight (in_pixel_weight),
    .in_coef_index   (in_coef_index),
    .in_coef_value   (in_coef_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_in_job)
  );

  sncv_queue #(.DEPTH(sncv_pkg::Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: horizontal pass, line buffers, vertical pass, divide
  sncv_back #(.MAX_COLS(MAX_COLS), .MAX_TAPS(MAX_TAPS), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head_job         (q_head_job),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_out_row      (out_out_row),
    .out_out_col      (out_out_col),
    .out_skipped      (out_skipped),
    .out_last         (out_last)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_skipped) |-> (out_result_value == 16'sd0))
    else $error("skipped item with non-zero value");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the normalized convolution core: a local predictor
// follows every accepted item and each result item is matched field by field.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS      = 15;
  localparam int NCOLS      = 2048;
  localparam int DRAIN      = 150;    // idle wait before reprogramming and at the end
  localparam int IDLE_LIMIT = 6000;   // cycles with no handshake at all
  localparam int HOLD_LEN   = 400;    // long receiver hold-off

  typedef struct {
    logic signed [15:0] value;
    logic [15:0]        row;
    logic [10:0]        col;
    logic               skip;
    logic               last;
  } pix_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_req_type;
  logic signed [15:0] in_pixel_value;
  logic [15:0]        in_pixel_weight;
  logic [3:0]         in_coef_index;
  logic signed [15:0] in_coef_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_result_value;
  logic [15:0]        out_out_row;
  logic [10:0]        out_out_col;
  logic               out_skipped;
  logic               out_last;

  separable_normalized_convolution_core dut (.*);

  // --------------------------------------------------------------------------
  // predictor state: taps, shift windows, line stores, counters, registers
  // --------------------------------------------------------------------------
  longint      h_taps [NTAPS];
  longint      v_taps [NTAPS];
  longint      pw_win [NTAPS];
  longint      wt_win [NTAPS];
  longint      line_sum [NTAPS][NCOLS];
  longint      line_wt  [NTAPS][NCOLS];
  int unsigned line_ctr [NTAPS][NCOLS];
  int unsigned row_pos, col_pos;
  int unsigned r_out_cols, r_pad_cols, r_out_rows, r_taps_c, r_taps_r;
  int unsigned r_nd_en, r_nd_val;

  pix_result_t expected_pixels[$];
  int          n_errors, n_pixels, n_loads, n_results, n_skipped;
  bit          gaps_on;
  int          stall_pct;
  bit          hold_on;
  event        start_hold;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half away from zero, drop 14 fraction bits
  function automatic longint drop_q14(longint x);
    longint mag;
    mag = x < 0 ? -x : x;
    mag = (mag + 8192) >>> 14;
    return x < 0 ? -mag : mag;
  endfunction

  function automatic longint norm_div(longint s, longint w);
    longint unsigned mag, q;
    mag = s < 0 ? longint'(-s) : s;
    q = (mag * 2 + longint'(w)) / (longint'(w) * 2);
    if (s < 0) return q > 32768 ? -32768 : -longint'(q);
    return q > 32767 ? 32767 : longint'(q);
  endfunction

  // Runs one pixel through the predictor; returns 1 when a result is due.
  function automatic bit predict_pixel(input logic signed [15:0] pv,
                                       input logic [15:0] pwt,
                                       output pix_result_t res);
    int unsigned pc, ocn, orows, tc, tr, r, c, oc, ring, orow, ctr, lastcol;
    longint p, w, sh, wh, s, ws, val;
    bit got;
    got = 1'b0;
    res = '{default: '0};
    pc    = clampu(r_pad_cols, 1, NCOLS);
    ocn   = clampu(r_out_cols, 1, NCOLS);
    orows = r_out_rows == 0 ? 1 : r_out_rows;
    tc    = clampu(r_taps_c, 1, NTAPS);
    tr    = clampu(r_taps_r, 1, NTAPS);
    p = pv;
    w = pwt > 16'd32768 ? 32768 : pwt;
    if (r_nd_en != 0 && pv == 16'(r_nd_val)) w = 0;
    for (int i = NTAPS - 1; i > 0; i--) begin
      pw_win[i] = pw_win[i-1];
      wt_win[i] = wt_win[i-1];
    end
    pw_win[0] = p * w;
    wt_win[0] = w;
    r = row_pos;
    c = col_pos;
    if (c >= tc - 1 && c - (tc - 1) < ocn) begin
      oc = c - (tc - 1);
      ring = r % NTAPS;
      sh = 0;
      wh = 0;
      for (int j = 0; j < tc; j++) begin
        sh += h_taps[j] * pw_win[tc-1-j];
        wh += h_taps[j] * wt_win[tc-1-j];
      end
      line_sum[ring][oc] = drop_q14(sh);
      line_wt[ring][oc]  = drop_q14(wh);
      line_ctr[ring][oc] = int'(wt_win[tc-1-tc/2]);
      if (r >= tr - 1 && r - (tr - 1) < orows) begin
        orow = r - (tr - 1);
        ctr = line_ctr[(orow + tr/2) % NTAPS][oc];
        lastcol = (ocn < pc - tc + 1 ? ocn : pc - tc + 1) - 1;
        val = 0;
        if (ctr == 0) begin
          res.skip = 1'b1;
        end else begin
          s = 0;
          ws = 0;
          for (int k = 0; k < tr; k++) begin
            s  += v_taps[k] * line_sum[(orow + k) % NTAPS][oc];
            ws += v_taps[k] * line_wt[(orow + k) % NTAPS][oc];
          end
          if (ws > 0) val = norm_div(s, ws);
        end
        res.value = 16'(val);
        res.row   = 16'(orow);
        res.col   = 11'(oc);
        res.last  = (orow == orows - 1 && oc == lastcol);
        got = 1'b1;
      end
    end
    if (c + 1 >= pc) begin
      col_pos = 0;
      row_pos = (r + 1 >= orows + tr - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int k;
    if (!gaps_on) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic [1:0] rt, input logic signed [15:0] pv,
                           input logic [15:0] pwt, input logic [3:0] ci,
                           input logic signed [15:0] cv);
    int gap;
    pix_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type     <= rt;
    in_pixel_value  <= pv;
    in_pixel_weight <= pwt;
    in_coef_index   <= ci;
    in_coef_value   <= cv;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    // item taken at this edge: update the predictor
    case (rt)
      sncv_pkg::REQ_PIXEL: begin
        n_pixels++;
        if (predict_pixel(pv, pwt, res)) expected_pixels.push_back(res);
      end
      sncv_pkg::REQ_HCOEF: begin
        n_loads++;
        if (ci < NTAPS) h_taps[ci] = cv;
      end
      sncv_pkg::REQ_VCOEF: begin
        n_loads++;
        if (ci < NTAPS) v_taps[ci] = cv;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sncv_pkg::CFG_OUT_COLS:    r_out_cols = val & 16'hFFF;
      sncv_pkg::CFG_PADDED_COLS: r_pad_cols = val & 16'hFFF;
      sncv_pkg::CFG_OUT_ROWS:    r_out_rows = val;
      sncv_pkg::CFG_TAPS_COLS:   r_taps_c   = val & 16'hF;
      sncv_pkg::CFG_TAPS_ROWS:   r_taps_r   = val & 16'hF;
      sncv_pkg::CFG_NODATA_EN:   r_nd_en    = val & 16'h1;
      sncv_pkg::CFG_NODATA_VAL:  r_nd_val   = val;
      default: ;
    endcase
  endtask

  // Full reprogram, only with the core idle and counters back at frame start.
  task automatic set_geometry(input int oc, input int pc, input int orows, input int tc,
                              input int tr, input bit nd_en, input logic [15:0] nd_val);
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    write_reg(sncv_pkg::CFG_OUT_COLS, 16'(oc));
    write_reg(sncv_pkg::CFG_PADDED_COLS, 16'(pc));
    write_reg(sncv_pkg::CFG_OUT_ROWS, 16'(orows));
    write_reg(sncv_pkg::CFG_TAPS_COLS, 16'(tc));
    write_reg(sncv_pkg::CFG_TAPS_ROWS, 16'(tr));
    write_reg(sncv_pkg::CFG_NODATA_EN, 16'(nd_en));
    write_reg(sncv_pkg::CFG_NODATA_VAL, nd_val);
  endtask

  function automatic logic [15:0] rand_weight();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 16'd32768;
    if (k < 55) return 16'd0;
    if (k < 65) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic signed [15:0] rand_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5)  return 16'sh7FFF;
    if (k < 10) return -16'sh8000;
    if (k < 22) return 16'(r_nd_val);
    return 16'($urandom);
  endfunction

  // mostly positive taps so weight sums stay positive; some fully random
  task automatic load_taps(input bit wild);
    for (int i = 0; i < NTAPS; i++) begin
      send_item(sncv_pkg::REQ_HCOEF, '0, '0, 4'(i),
                wild ? 16'($urandom) : 16'($urandom_range(0, 16384)));
      send_item(sncv_pkg::REQ_VCOEF, '0, '0, 4'(i),
                wild ? 16'($urandom) : 16'($urandom_range(0, 16384)));
    end
  endtask

  // Padded rows of input; nrows 0 = one whole frame, so counters end at zero.
  task automatic send_frame(input int nrows);
    int unsigned pc, rows;
    pc = clampu(r_pad_cols, 1, NCOLS);
    rows = (r_out_rows == 0 ? 1 : r_out_rows) + clampu(r_taps_r, 1, NTAPS) - 1;
    if (nrows > 0) rows = nrows;
    for (int unsigned i = 0; i < pc * rows; i++)
      send_item(sncv_pkg::REQ_PIXEL, rand_value(), rand_weight(), 4'($urandom),
                16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // receiver side and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  initial begin
    forever begin
      @(start_hold);
      hold_on = 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  int stall_run;
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_skipped) n_skipped++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected item row %0d col %0d", out_out_row, out_out_col));
      end else begin
        e = expected_pixels.pop_front();
        if (out_result_value !== e.value)
          report_mismatch($sformatf("value %0d, want %0d (row %0d col %0d)",
                                    out_result_value, e.value, e.row, e.col));
        if (out_out_row !== e.row)
          report_mismatch($sformatf("row %0d, want %0d", out_out_row, e.row));
        if (out_out_col !== e.col)
          report_mismatch($sformatf("col %0d, want %0d", out_out_col, e.col));
        if (out_skipped !== e.skip)
          report_mismatch($sformatf("skipped %0b, want %0b", out_skipped, e.skip));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
      end
    end
    // stall pattern: long hold-off on request, else bursts short and long
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                               : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no handshake on any port
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // taps, an out-of-range tap index and an unused request code
  task automatic test_coef_loads();
    load_taps(1'b0);
    send_item(sncv_pkg::REQ_HCOEF, '0, '0, 4'd15, 16'sh7FFF);   // ignored
    send_item(sncv_pkg::REQ_VCOEF, '0, '0, 4'd15, -16'sh8000);  // ignored
    send_item(sncv_pkg::REQ_NONE, 16'sh1234, 16'hFFFF, 4'd0, 16'sh7FFF);
  endtask

  // small hand-made frame: extremes, no-data, zero centre, weight above one
  task automatic test_directed_frame();
    logic signed [15:0] pv [8] = '{16'sh7FFF, -16'sh8000, 16'sd100, 16'sd0,
                                   -16'sd5, 16'sd100, 16'sh7FFF, -16'sh8000};
    logic [15:0] wt [8] = '{16'd32768, 16'hFFFF, 16'd32768, 16'd0,
                            16'd0, 16'd16384, 16'd32769, 16'd1};
    set_geometry(3, 4, 1, 2, 2, 1'b1, 16'sd100);
    for (int i = 0; i < 8; i++)
      send_item(sncv_pkg::REQ_PIXEL, pv[i], wt[i], '0, '0);
    // all-zero weights: weight sum not positive
    for (int i = 0; i < 8; i++)
      send_item(sncv_pkg::REQ_PIXEL, 16'($urandom), 16'd0, '0, '0);
  endtask

  // output wider than the padded row allows
  task automatic test_narrow_padding();
    set_geometry(8, 4, 2, 3, 1, 1'b0, 16'sh7FFF);
    send_frame(0);
  endtask

  // zero registers clamp up, all-ones clamp down; tap lengths at both ends
  task automatic test_register_extremes();
    set_geometry(0, 0, 0, 0, 0, 1'b1, -16'sh8000);
    send_frame(0);
    send_frame(0);
    set_geometry(16'hFFF, 20, 1, 15, 1, 1'b0, 16'sh7FFF);
    send_frame(0);
    set_geometry(2, 16, 2, 15, 15, 1'b0, 16'd0);
    send_frame(0);
  endtask

  // receiver holds off while the sender keeps going, then sender waits
  task automatic test_backpressure();
    set_geometry(6, 8, 3, 3, 3, 1'b0, 16'd0);
    gaps_on = 1'b0;
    -> start_hold;
    send_frame(0);
    wait_drained();
    gaps_on = 1'b1;
    send_frame(0);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 100) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4),
                   $urandom_range(1, 6), $urandom_range(1, 5), 1'($urandom),
                   16'($urandom));
      gaps_on   = $urandom_range(0, 3) != 0;
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) load_taps($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        send_item(sncv_pkg::REQ_NONE, 16'($urandom), 16'($urandom), 4'($urandom),
                  16'($urandom));
      sent -= n_pixels;
      send_frame(0);
      sent += n_pixels;
    end
    // tallest block: a few rows only, no further reprogramming after this
    set_geometry(5, 7, 16'hFFFF, 3, 3, 1'b0, 16'd0);
    send_frame(4);
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_req_type     <= sncv_pkg::REQ_PIXEL;
    in_pixel_value  <= '0;
    in_pixel_weight <= '0;
    in_coef_index   <= '0;
    in_coef_value   <= '0;
    out_stall       <= 1'b0;
    hold_on    = 1'b0;
    gaps_on    = 1'b1;
    stall_pct  = 20;
    stall_run  = 0;
    n_errors   = 0;
    n_pixels   = 0;
    n_loads    = 0;
    n_results  = 0;
    n_skipped  = 0;
    row_pos    = 0;
    col_pos    = 0;
    r_out_cols = 1;
    r_pad_cols = 1;
    r_out_rows = 1;
    r_taps_c   = 1;
    r_taps_r   = 1;
    r_nd_en    = 0;
    r_nd_val   = 0;
    foreach (h_taps[i]) begin
      h_taps[i] = 0;
      v_taps[i] = 0;
      pw_win[i] = 0;
      wt_win[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_coef_loads();
    test_directed_frame();
    test_narrow_padding();
    test_register_extremes();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d items never arrived", expected_pixels.size()));
    $display("Covered %0d pixels and %0d tap loads; %0d results checked, %0d skipped.",
             n_pixels, n_loads, n_results, n_skipped);
    $display("Frames spanned clamped, narrow, widest and tallest geometries; %0d mismatches.",
             n_errors);
    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
